FILE: rtl/core/pgd_pkg.sv
// pgd_pkg: shared types, genotype codes and fixed-point constants for the
// packed genotype decoder. No dependencies.
package pgd_pkg;

  // lanes per byte and the width of one genotype code
  localparam int SLOTS  = 4;
  localparam int CODE_W = 2;

  // width of the sample count register
  localparam int CFG_W = 21;

  // quotient bits produced by the row-end divider
  localparam int QW = 16;

  // numerator shifts: mean is Q2.14 of S/N -> (S << 15 + N) / 2N,
  // maf is Q0.16 of m/2N -> (m << 16 + N) / 2N
  localparam int MEAN_SHIFT = 15;
  localparam int MAF_SHIFT  = 16;

  // genotype codes
  localparam logic [CODE_W-1:0] CODE_HOM_A = 2'b00;
  localparam logic [CODE_W-1:0] CODE_MISS  = 2'b01;
  localparam logic [CODE_W-1:0] CODE_HET   = 2'b10;
  localparam logic [CODE_W-1:0] CODE_HOM_B = 2'b11;

  typedef struct packed {
    logic [7:0]  genotype_byte;
    logic [3:0]  include_mask;
    logic [23:0] variant_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  dosage_slot0;
    logic [1:0]  dosage_slot1;
    logic [1:0]  dosage_slot2;
    logic [1:0]  dosage_slot3;
    logic [3:0]  slot_valid_mask;
    logic [3:0]  missing_mask;
    logic        row_done;
    logic [15:0] imputed_mean;
    logic [15:0] minor_allele_freq;
    logic        all_missing;
    logic [23:0] variant_out;
  } out_item_t;

  // what one lane reports for its slot
  typedef struct packed {
    logic [1:0] dose;
    logic       valid;
    logic       miss;
    logic       called;
  } lane_res_t;

  // merged view of one byte
  typedef struct packed {
    logic [SLOTS-1:0] valid_mask;
    logic [SLOTS-1:0] miss_mask;
    logic [2:0]       called_inc;
    logic [3:0]       dose_inc;
  } merge_t;

  function automatic logic [1:0] decode_dose(input logic [CODE_W-1:0] code);
    logic [1:0] d;
    case (code)
      CODE_HOM_A: d = 2'd2;
      CODE_HET:   d = 2'd1;
      CODE_HOM_B: d = 2'd0;
      default:    d = 2'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/pgd_lane.sv
// pgd_lane: decodes one 2-bit genotype slot and checks it against the row.
// Depends on pgd_pkg.
module pgd_lane #(
  parameter int SEW  = 21,
  parameter int CW   = 21,
  parameter int SLOT = 0
) (
  input  logic [pgd_pkg::CODE_W-1:0] code,
  input  logic                       include_bit,
  input  logic [SEW-1:0]             seen,
  input  logic [CW-1:0]              count,
  output pgd_pkg::lane_res_t         res
);

  logic in_range;

  assign in_range = ((SEW+1)'(seen) + (SEW+1)'(SLOT)) < (SEW+1)'(count);

  always_comb begin
    res.valid  = in_range && include_bit;
    res.miss   = res.valid && (code == pgd_pkg::CODE_MISS);
    res.called = res.valid && (code != pgd_pkg::CODE_MISS);
    res.dose   = res.called ? pgd_pkg::decode_dose(code) : 2'd0;
  end

endmodule

FILE: rtl/core/pgd_merge.sv
// pgd_merge: combines the four lane reports into byte masks and increments.
// Depends on pgd_pkg.
module pgd_merge (
  input  pgd_pkg::lane_res_t [pgd_pkg::SLOTS-1:0] lanes,
  output pgd_pkg::merge_t                         merged
);

  always_comb begin
    merged.called_inc = '0;
    merged.dose_inc   = '0;
    for (int k = 0; k < pgd_pkg::SLOTS; k++) begin
      merged.valid_mask[k] = lanes[k].valid;
      merged.miss_mask[k]  = lanes[k].miss;
      merged.called_inc    = merged.called_inc + 3'(lanes[k].called);
      merged.dose_inc      = merged.dose_inc + 4'(lanes[k].dose);
    end
  end

endmodule

FILE: rtl/core/pgd_div.sv
// pgd_div: restoring divider, one quotient bit per cycle, 16-bit quotient.
// The caller guarantees the quotient fits in QW bits. Depends on pgd_pkg.
module pgd_div #(
  parameter int DEN_W = 22
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [DEN_W+pgd_pkg::QW-1:0]   num,
  input  logic [DEN_W-1:0]               den,
  output logic                           done,
  output logic [pgd_pkg::QW-1:0]         quot
);

  localparam int QW    = pgd_pkg::QW;
  localparam int NUM_W = DEN_W + QW;
  localparam int CNT_W = $clog2(QW);

  logic [DEN_W-1:0] rem_r;
  logic [QW-1:0]    low_r;
  logic [QW-1:0]    q_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, low_r[QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    // datapath, no reset
    if (start) begin
      rem_r <= num[NUM_W-1:QW];
      low_r <= num[QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: rtl/core/packed_genotype_decode_allele_freq.sv
// packed_genotype_decode_allele_freq: top level, four decode lanes, merge,
// row counters and row-end statistics. Depends on pgd_pkg, pgd_lane,
// pgd_merge and pgd_div.

// Takes one byte of a packed variant row per request (four 2-bit genotype
// codes, slot 0 in bits 1:0) and returns one result per request: the four
// decoded dosages, the valid and missing masks and the echoed variant index.
// A byte that does not end the row has its result in the output register
// the cycle after it is taken. The byte that reaches the sample count ends
// the row; its result is registered once the shared 16-step restoring
// divider has run twice, once for the Q2.14 imputation mean and once for
// the Q0.16 minor allele frequency, and the input stalls for that whole
// time. A row with no called genotype skips the divider and returns
// all_missing at once. A new request is taken only when the output register
// is empty or its result leaves in the same cycle, so a stalled result
// holds off the input, and never while the divider runs.
// The sample count is clamped to 1..MAX_SAMPLES when written, and should
// only be written while no request is in flight; cfg_ready is always high.
module packed_genotype_decode_allele_freq #(
  parameter int MAX_SAMPLES = 1048576
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pgd_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pgd_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pgd_pkg::CFG_W-1:0]   cfg_data
);

  // count widths follow from the largest row
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int SEW   = $clog2(MAX_SAMPLES + 4);
  localparam int SW    = CW + 1;
  localparam int DEN_W = CW + 1;
  localparam int NUM_W = DEN_W + pgd_pkg::QW;
  localparam int SLOTS = pgd_pkg::SLOTS;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MAF_GO,
    ST_MAF_WAIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [SEW-1:0]     seen_r, seen_nxt;
  logic [CW-1:0]      called_r, called_nxt;
  logic [SW-1:0]      total_r, total_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [SW-1:0]      s_r, s_nxt;
  logic               out_valid_r, out_valid_nxt;
  pgd_pkg::out_item_t out_data_r, out_data_nxt;

  // lanes and merge
  pgd_pkg::lane_res_t [SLOTS-1:0] lanes;
  pgd_pkg::merge_t                merged;

  // divider
  logic                     div_start;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_done;
  logic [pgd_pkg::QW-1:0]   div_quot;

  logic               in_take;
  logic               cfg_take;
  logic [31:0]        cfg_ext;
  logic [SEW:0]       seen_sum;
  logic               row_end;
  logic [CW-1:0]      called_sum;
  logic [SW-1:0]      total_sum;
  logic [SW-1:0]      two_n;
  logic [SW-1:0]      other_side;
  logic [SW-1:0]      minor_s;

  genvar k;
  generate
    for (k = 0; k < SLOTS; k++) begin : g_lane
      pgd_lane #(
        .SEW  (SEW),
        .CW   (CW),
        .SLOT (k)
      ) u_lane (
        .code        (in_data.genotype_byte[pgd_pkg::CODE_W*k +: pgd_pkg::CODE_W]),
        .include_bit (in_data.include_mask[k]),
        .seen        (seen_r),
        .count       (count_r),
        .res         (lanes[k])
      );
    end
  endgenerate

  pgd_merge u_merge (
    .lanes  (lanes),
    .merged (merged)
  );

  pgd_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // handshakes
  assign in_stall  = !((state_r == ST_RUN) && (!out_valid_r || !out_stall));
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign cfg_ext   = 32'(cfg_data);

  // row position and updated counters for the byte at the input
  assign seen_sum   = (SEW+1)'(seen_r) + (SEW+1)'(SLOTS);
  assign row_end    = seen_sum >= (SEW+1)'(count_r);
  assign called_sum = called_r + CW'(merged.called_inc);
  assign total_sum  = total_r + SW'(merged.dose_inc);

  // minor side of the allele count, min(S, 2N - S)
  assign two_n      = {n_r, 1'b0};
  assign other_side = two_n - s_r;
  assign minor_s    = (s_r <= other_side) ? s_r : other_side;

  assign div_den = two_n;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    seen_nxt      = seen_r;
    called_nxt    = called_r;
    total_nxt     = total_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_num       = '0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // clamp the sample count to 1..MAX_SAMPLES
    if (cfg_take) begin
      if (cfg_ext == 32'd0) begin
        count_nxt = CW'(1);
      end else if (cfg_ext > 32'(MAX_SAMPLES)) begin
        count_nxt = CW'(MAX_SAMPLES);
      end else begin
        count_nxt = CW'(cfg_ext);
      end
    end

    case (state_r)
      ST_RUN: begin
        if (in_take) begin
          out_data_nxt.dosage_slot0      = lanes[0].dose;
          out_data_nxt.dosage_slot1      = lanes[1].dose;
          out_data_nxt.dosage_slot2      = lanes[2].dose;
          out_data_nxt.dosage_slot3      = lanes[3].dose;
          out_data_nxt.slot_valid_mask   = merged.valid_mask;
          out_data_nxt.missing_mask      = merged.miss_mask;
          out_data_nxt.row_done          = row_end;
          out_data_nxt.imputed_mean      = '0;
          out_data_nxt.minor_allele_freq = '0;
          out_data_nxt.all_missing       = 1'b0;
          out_data_nxt.variant_out       = in_data.variant_index;
          if (row_end) begin
            // counters clear for the next row, operands held for the divider
            seen_nxt   = '0;
            called_nxt = '0;
            total_nxt  = '0;
            n_nxt      = called_sum;
            s_nxt      = total_sum;
            if (called_sum == '0) begin
              out_data_nxt.all_missing = 1'b1;
              out_valid_nxt            = 1'b1;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = ST_MEAN_GO;
            end
          end else begin
            seen_nxt      = seen_sum[SEW-1:0];
            called_nxt    = called_sum;
            total_nxt     = total_sum;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_MEAN_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'({s_r, pgd_pkg::MEAN_SHIFT'(0)}) + NUM_W'(n_r);
        state_nxt = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          out_data_nxt.imputed_mean = div_quot;
          state_nxt                 = ST_MAF_GO;
        end
      end
      ST_MAF_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'({minor_s, pgd_pkg::MAF_SHIFT'(0)}) + NUM_W'(n_r);
        state_nxt = ST_MAF_WAIT;
      end
      ST_MAF_WAIT: begin
        if (div_done) begin
          out_data_nxt.minor_allele_freq = div_quot;
          out_valid_nxt                  = 1'b1;
          state_nxt                      = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      count_r     <= CW'(1);
      seen_r      <= '0;
      called_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      seen_r      <= seen_nxt;
      called_r    <= called_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload, no reset
    n_r        <= n_nxt;
    s_r        <= s_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider only reports back while a row end waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_MEAN_WAIT || state_r == ST_MAF_WAIT))
    else $error("divider finished outside a wait state");

  // an all-missing row ends the row and carries zero statistics
  a_all_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.all_missing) |->
      (out_data.row_done && out_data.imputed_mean == 16'd0 &&
       out_data.minor_allele_freq == 16'd0))
    else $error("all_missing result with nonzero statistics");

  // missing slots are always valid slots
  a_miss_in_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.missing_mask & ~out_data.slot_valid_mask) == 4'd0))
    else $error("missing bit set on a slot that is not valid");

  // mean is at most 2.0 and maf at most 0.5
  a_stat_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.row_done) |->
      (out_data.imputed_mean <= 16'd32768 && out_data.minor_allele_freq <= 16'd32768))
    else $error("row statistic out of range");

endmodule
